// ===== rtl/kcst_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed counting semaphore table: shared package
// Sizes, operation and status codes, the slot row layout and the result
// record of the shared arithmetic and compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcst_pkg;

  // Table sizes.
  localparam int SEMAPHORES      = 16;
  localparam int WAITERS_PER_SEM = 16;
  localparam int TASKS           = 16;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int COUNT_W  = 16;
  localparam int TASK_W   = 4;
  localparam int STATUS_W = 3;
  localparam int RKEY_W   = 32;

  // Derived widths.
  localparam int SLOT_IW  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int HEAD_W   = (WAITERS_PER_SEM > 1) ? $clog2(WAITERS_PER_SEM) : 1;
  localparam int FILL_W   = $clog2(WAITERS_PER_SEM + 1);
  localparam int WQ_DEPTH = SEMAPHORES * WAITERS_PER_SEM;
  localparam int WQ_AW    = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_UP      = 2'd1;
  localparam logic [OP_W-1:0] OP_DOWN    = 2'd2;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QFULL     = 3'd4;

  // Count limits.
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  // One row of the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [HEAD_W-1:0]  head;
    logic [FILL_W-1:0]  fill;
  } slot_row_t;

  // Outputs of the shared arithmetic and compare unit.
  typedef struct packed {
    logic               key_eq;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_dec;
    logic [HEAD_W-1:0]  head_inc;
    logic [HEAD_W-1:0]  tail;
  } alu_res_t;

  // Reduce a task id modulo TASKS by repeated subtraction.
  function automatic logic [TASK_W-1:0] task_wrap(input logic [TASK_W-1:0] t);
    logic [TASK_W-1:0] v;
    v = t;
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= TASKS) begin
        v = v - TASK_W'(TASKS);
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/keyed_counting_semaphore_table_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed counting semaphore table unit
// A table of counting semaphores looked up by a 31-bit key, with a first-in
// first-out wait queue per semaphore.
// - Input channel in_*: one request transaction (operation, key, initial
//   count, task id), taken when in_valid is high and in_stall low.
// - Output channel out_*: exactly one result transaction per request
//   (status, returned key, wake flag, woken task), held in an output
//   register until the receiver takes it with out_stall low.
// - The key scan reads one slot row per cycle into one shared comparator; a
//   key found in slot j ends the scan early. An up that wakes a waiter also
//   passes through the wake state, which reads the woken task, before the
//   result is loaded.
// - One request is in work at a time; in_stall is high from acceptance until
//   the result is loaded. The next request can be taken in the cycle after
//   the result is loaded.
// - When the receiver stalls, the waiting result holds the output register;
//   the next request is still worked on, then in_stall stays high until the
//   output register is taken.
// - Reset frees every slot at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_counting_semaphore_table_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [kcst_pkg::OP_W-1:0]          in_operation,
  input  wire logic [kcst_pkg::KEY_W-1:0]         in_sem_key,
  input  wire logic signed [kcst_pkg::COUNT_W-1:0] in_initial_count,
  input  wire logic [kcst_pkg::TASK_W-1:0]        in_task_id,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [kcst_pkg::STATUS_W-1:0]           out_status,
  output logic signed [kcst_pkg::RKEY_W-1:0]      out_returned_key,
  output logic                                    out_wake_valid,
  output logic [kcst_pkg::TASK_W-1:0]             out_woken_task
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WAKE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [kcst_pkg::SLOT_IW-1:0] LAST_SLOT =
    kcst_pkg::SLOT_IW'(kcst_pkg::SEMAPHORES - 1);
  localparam int ROW_W = $bits(kcst_pkg::slot_row_t);

  logic [2:0] state_r, state_nxt;

  // Request registers.
  logic [kcst_pkg::OP_W-1:0]    op_r;
  logic [kcst_pkg::KEY_W-1:0]   key_r;
  logic [kcst_pkg::COUNT_W-1:0] init_r;
  logic [kcst_pkg::TASK_W-1:0]  task_r;

  // Scan control.
  logic [kcst_pkg::SLOT_IW-1:0] scan_idx_r;
  logic                         issue_en_r;
  logic                         cmp_vld_r;
  logic [kcst_pkg::SLOT_IW-1:0] cmp_idx_r;
  logic                         hit_r;
  logic [kcst_pkg::SLOT_IW-1:0] slot_r;
  logic                         free_found_r;
  logic [kcst_pkg::SLOT_IW-1:0] free_idx_r;
  kcst_pkg::slot_row_t          row_r;

  logic [kcst_pkg::SEMAPHORES-1:0] slot_used_r;

  // Result staging and output register.
  logic [kcst_pkg::STATUS_W-1:0] res_status_r;
  logic [kcst_pkg::RKEY_W-1:0]   res_rkey_r;
  logic                          res_wake_r;
  logic [kcst_pkg::TASK_W-1:0]   res_woken_r;
  logic                          out_valid_r;

  // Memory ports.
  kcst_pkg::slot_row_t          row_rd, row_wd, alu_row;
  logic [ROW_W-1:0]             row_rd_bits;
  logic                         row_we;
  logic [kcst_pkg::SLOT_IW-1:0] row_wa;
  logic                         wq_we;
  logic [kcst_pkg::WQ_AW-1:0]   wq_wa, wq_ra, wq_base;
  logic [kcst_pkg::TASK_W-1:0]  wq_wd, wq_rd;

  kcst_pkg::alu_res_t alu;

  // Execute-stage decisions.
  logic                          used_set, used_clr;
  logic [kcst_pkg::STATUS_W-1:0] ex_status;
  logic [kcst_pkg::RKEY_W-1:0]   ex_rkey;
  logic                          ex_wake;
  logic                          scan_hit;
  logic                          out_load;

  assign row_rd = kcst_pkg::slot_row_t'(row_rd_bits);

  // Slot memory: key, count and queue pointers of every semaphore.
  kcst_ram #(
    .WIDTH (ROW_W),
    .DEPTH (kcst_pkg::SEMAPHORES)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_wa),
    .wr_data (ROW_W'(row_wd)),
    .rd_addr (scan_idx_r),
    .rd_data (row_rd_bits)
  );

  // Waiter memory: one queue region per slot.
  kcst_ram #(
    .WIDTH (kcst_pkg::TASK_W),
    .DEPTH (kcst_pkg::WQ_DEPTH)
  ) u_waiter_ram (
    .clk     (clk),
    .wr_en   (wq_we),
    .wr_addr (wq_wa),
    .wr_data (wq_wd),
    .rd_addr (wq_ra),
    .rd_data (wq_rd)
  );

  // The shared unit sees the memory read data while scanning, the held row otherwise.
  assign alu_row = (state_r == S_SCAN) ? row_rd : row_r;

  kcst_alu u_alu (
    .row     (alu_row),
    .req_key (key_r),
    .res     (alu)
  );

  assign scan_hit = cmp_vld_r && slot_used_r[cmp_idx_r] && alu.key_eq;

  // Waiter addresses for the slot in work.
  assign wq_base = kcst_pkg::WQ_AW'(slot_r) * kcst_pkg::WQ_AW'(kcst_pkg::WAITERS_PER_SEM);
  assign wq_ra   = wq_base + kcst_pkg::WQ_AW'(row_r.head);
  assign wq_wa   = wq_base + kcst_pkg::WQ_AW'(alu.tail);
  assign wq_wd   = kcst_pkg::task_wrap(task_r);

  // Execute step: one read-modify-write of the selected slot.
  always_comb begin
    row_we    = 1'b0;
    row_wa    = slot_r;
    row_wd    = row_r;
    wq_we     = 1'b0;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    ex_status = kcst_pkg::ST_OK;
    ex_rkey   = '0;
    ex_wake   = 1'b0;
    if (state_r == S_EXEC) begin
      if (op_r == kcst_pkg::OP_INIT) begin
        if (hit_r) begin
          ex_rkey = {1'b0, key_r};
        end else if (free_found_r) begin
          row_we       = 1'b1;
          row_wa       = free_idx_r;
          row_wd.key   = key_r;
          row_wd.count = init_r;
          row_wd.head  = '0;
          row_wd.fill  = '0;
          used_set     = 1'b1;
          ex_rkey      = {1'b0, key_r};
        end else begin
          ex_status = kcst_pkg::ST_FULL;
          ex_rkey   = '1;
        end
      end else if (!hit_r) begin
        ex_status = kcst_pkg::ST_NOT_FOUND;
      end else begin
        unique case (op_r)
          kcst_pkg::OP_UP: begin
            row_we       = 1'b1;
            row_wd.count = alu.count_inc;
            if (($signed(alu.count_inc) <= 0) && (row_r.fill != '0)) begin
              ex_wake     = 1'b1;
              row_wd.head = alu.head_inc;
              row_wd.fill = row_r.fill - kcst_pkg::FILL_W'(1);
            end
          end
          kcst_pkg::OP_DOWN: begin
            if ($signed(alu.count_dec) < 0) begin
              if (row_r.fill == kcst_pkg::FILL_W'(kcst_pkg::WAITERS_PER_SEM)) begin
                ex_status = kcst_pkg::ST_QFULL;
              end else begin
                row_we       = 1'b1;
                wq_we        = 1'b1;
                row_wd.count = alu.count_dec;
                row_wd.fill  = row_r.fill + kcst_pkg::FILL_W'(1);
                ex_status    = kcst_pkg::ST_BLOCKED;
              end
            end else begin
              row_we       = 1'b1;
              row_wd.count = alu.count_dec;
            end
          end
          kcst_pkg::OP_DESTROY: begin
            used_clr = 1'b1;
          end
          default: begin
            ex_status = kcst_pkg::ST_OK;
          end
        endcase
      end
    end
  end

  // Result moves into the output register once that register is free.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit || (cmp_vld_r && (cmp_idx_r == LAST_SLOT))) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = ex_wake ? S_WAKE : S_DONE;
      end
      S_WAKE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_en_r   <= 1'b0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      slot_used_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Scan pipeline: issue a row read, compare it in the next cycle.
      if (state_r == S_IDLE) begin
        issue_en_r   <= 1'b1;
        cmp_vld_r    <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        cmp_vld_r <= issue_en_r && !scan_hit;
        if (issue_en_r && (scan_idx_r == LAST_SLOT)) begin
          issue_en_r <= 1'b0;
        end
        if (scan_hit) begin
          hit_r      <= 1'b1;
          issue_en_r <= 1'b0;
        end else if (cmp_vld_r && !slot_used_r[cmp_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end

      if (used_set) begin
        slot_used_r[free_idx_r] <= 1'b1;
      end
      if (used_clr) begin
        slot_used_r[slot_r] <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      op_r       <= in_operation;
      key_r      <= in_sem_key;
      init_r     <= in_initial_count;
      task_r     <= in_task_id;
      scan_idx_r <= '0;
    end else if ((state_r == S_SCAN) && issue_en_r && (scan_idx_r != LAST_SLOT)) begin
      scan_idx_r <= scan_idx_r + kcst_pkg::SLOT_IW'(1);
    end

    if (state_r == S_SCAN) begin
      cmp_idx_r <= scan_idx_r;
      if (scan_hit) begin
        slot_r <= cmp_idx_r;
        row_r  <= row_rd;
      end else if (cmp_vld_r && !slot_used_r[cmp_idx_r] && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end

    if (state_r == S_EXEC) begin
      res_status_r <= ex_status;
      res_rkey_r   <= ex_rkey;
      res_wake_r   <= ex_wake;
      res_woken_r  <= '0;
    end
    if (state_r == S_WAKE) begin
      res_woken_r <= wq_rd;
    end

    if (out_load) begin
      out_status       <= res_status_r;
      out_returned_key <= res_rkey_r;
      out_wake_valid   <= res_wake_r;
      out_woken_task   <= res_woken_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // An accepted request keeps the request side closed in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request side open right after an accepted transaction");

  // A woken task is only reported with an ok status.
  a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake_valid) |-> (out_status == kcst_pkg::ST_OK))
    else $error("wake reported with a non-ok status");

  // A full table always returns the all-ones key.
  a_full_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == kcst_pkg::ST_FULL)) |-> (out_returned_key == '1))
    else $error("table full without the all-ones key");

  // Queue fill written back never exceeds the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> (row_wd.fill <= kcst_pkg::FILL_W'(kcst_pkg::WAITERS_PER_SEM)))
    else $error("queue fill beyond depth");

endmodule

`default_nettype wire

// ===== rtl/kcst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/kcst_alu.sv =====
// ----------------------------------------------------------------------------
// Keyed counting semaphore table: shared arithmetic and compare unit
// Key compare during the slot scan; saturating count steps and wait queue
// index wrapping during execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcst_alu (
  input  wire kcst_pkg::slot_row_t              row,
  input  wire logic [kcst_pkg::KEY_W-1:0]       req_key,
  output kcst_pkg::alu_res_t                    res
);

  logic [kcst_pkg::FILL_W:0] tail_sum;

  // Key match against the row that is presented.
  assign res.key_eq = (row.key == req_key);

  // Saturating increment and decrement of the count.
  assign res.count_inc = ($signed(row.count) < kcst_pkg::COUNT_MAX) ?
                         row.count + kcst_pkg::COUNT_W'(1) : row.count;
  assign res.count_dec = ($signed(row.count) > kcst_pkg::COUNT_MIN) ?
                         row.count - kcst_pkg::COUNT_W'(1) : row.count;

  // Head advance wraps at the queue depth.
  assign res.head_inc =
    (row.head == kcst_pkg::HEAD_W'(kcst_pkg::WAITERS_PER_SEM - 1)) ?
    '0 : row.head + kcst_pkg::HEAD_W'(1);

  // Tail index is head plus fill, wrapped once (the sum stays below twice the depth).
  assign tail_sum = (kcst_pkg::FILL_W + 1)'(row.head) + (kcst_pkg::FILL_W + 1)'(row.fill);
  assign res.tail =
    (tail_sum >= (kcst_pkg::FILL_W + 1)'(kcst_pkg::WAITERS_PER_SEM)) ?
    kcst_pkg::HEAD_W'(tail_sum - (kcst_pkg::FILL_W + 1)'(kcst_pkg::WAITERS_PER_SEM)) :
    kcst_pkg::HEAD_W'(tail_sum);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Keyed counting semaphore table unit testbench
// Sends request transactions on the valid/stall request channel and checks
// every result transaction against a behavioral copy of the semaphore table
// kept in this file. A short directed table opens the run. Random request
// sequences follow: queue fills, table fills, mixed traffic and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kcst_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 800;
  localparam int POOL_SIZE    = 20;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP      = 13;

  localparam logic [KEY_W-1:0] K_ZERO = 31'h0000_0000;
  localparam logic [KEY_W-1:0] K_TOP  = 31'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] K_A    = 31'h2AAA_5555;
  localparam logic [KEY_W-1:0] K_B    = 31'h5555_2AAA;

  // One result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RKEY_W-1:0]   rkey;
    logic                wake;
    logic [TASK_W-1:0]   woken;
  } sem_result_t;

  // One row of the directed table; res is used only when typed is set.
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [KEY_W-1:0]          key;
    logic signed [COUNT_W-1:0] cnt;
    logic [TASK_W-1:0]         tid;
    logic                      typed;
    sem_result_t               res;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [OP_W-1:0]             in_operation;
  logic [KEY_W-1:0]            in_sem_key;
  logic signed [COUNT_W-1:0]   in_initial_count;
  logic [TASK_W-1:0]           in_task_id;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [STATUS_W-1:0]         out_status;
  logic signed [RKEY_W-1:0]    out_returned_key;
  logic                        out_wake_valid;
  logic [TASK_W-1:0]           out_woken_task;

  // Behavioral copy of the semaphore table.
  logic                        tbl_used [SEMAPHORES];
  logic [KEY_W-1:0]            tbl_key [SEMAPHORES];
  logic signed [COUNT_W-1:0]   tbl_count [SEMAPHORES];
  logic [TASK_W-1:0]           wait_ring [SEMAPHORES][WAITERS_PER_SEM];
  int                          ring_head [SEMAPHORES];
  int                          ring_fill [SEMAPHORES];

  sem_result_t                 pending_results[$];
  int                          errors = 0;
  int                          idle_cycles = 0;
  int                          results_seen = 0;
  int                          stall_drawn_for = -1;
  int                          stall_hold = 0;
  int                          requests_sent = 0;
  bit                          no_idle = 1'b0;

  keyed_counting_semaphore_table_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_sem_key       (in_sem_key),
    .in_initial_count (in_initial_count),
    .in_task_id       (in_task_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_returned_key (out_returned_key),
    .out_wake_valid   (out_wake_valid),
    .out_woken_task   (out_woken_task)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the table copy and returns its result.
  function automatic sem_result_t apply_request(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic signed [COUNT_W-1:0] cnt,
                                                input logic [TASK_W-1:0] tid);
    sem_result_t               r;
    int                        hit;
    int                        free_slot;
    int                        pos;
    logic signed [COUNT_W-1:0] next;
    r = '0;
    hit = -1;
    free_slot = -1;
    // Walk downward so that the lowest free slot wins.
    for (int s = SEMAPHORES - 1; s >= 0; s--) begin
      if (tbl_used[s] && tbl_key[s] == key) hit = s;
      if (!tbl_used[s]) free_slot = s;
    end
    if (op == OP_INIT) begin
      if (hit >= 0) begin
        r.rkey = {1'b0, key};
      end else if (free_slot >= 0) begin
        tbl_used[free_slot]  = 1'b1;
        tbl_key[free_slot]   = key;
        tbl_count[free_slot] = cnt;
        ring_head[free_slot] = 0;
        ring_fill[free_slot] = 0;
        r.rkey = {1'b0, key};
      end else begin
        r.status = ST_FULL;
        r.rkey   = '1;
      end
    end else if (hit < 0) begin
      r.status = ST_NOT_FOUND;
    end else if (op == OP_UP) begin
      // Saturating increment, then wake the head waiter if the count allows.
      if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 16'sd1;
      if (tbl_count[hit] <= 0 && ring_fill[hit] > 0) begin
        r.wake  = 1'b1;
        r.woken = wait_ring[hit][ring_head[hit]];
        ring_head[hit] = (ring_head[hit] + 1) % WAITERS_PER_SEM;
        ring_fill[hit]--;
      end
    end else if (op == OP_DOWN) begin
      // Saturating decrement; a negative result queues the caller.
      next = (tbl_count[hit] != COUNT_MIN) ? tbl_count[hit] - 16'sd1 : COUNT_MIN;
      if (next < 0) begin
        if (ring_fill[hit] >= WAITERS_PER_SEM) begin
          r.status = ST_QFULL;
        end else begin
          pos = (ring_head[hit] + ring_fill[hit]) % WAITERS_PER_SEM;
          wait_ring[hit][pos] = TASK_W'(int'(tid) % TASKS);
          ring_fill[hit]++;
          tbl_count[hit] = next;
          r.status = ST_BLOCKED;
        end
      end else begin
        tbl_count[hit] = next;
      end
    end else begin
      tbl_used[hit]  = 1'b0;
      ring_head[hit] = 0;
      ring_fill[hit] = 0;
    end
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input int cnt, input int tid, input logic typed,
                                         input logic [STATUS_W-1:0] st,
                                         input logic [RKEY_W-1:0] rkey,
                                         input logic wake, input int woken);
    stim_row_t r;
    r.op           = op;
    r.key          = key;
    r.cnt          = COUNT_W'(cnt);
    r.tid          = TASK_W'(tid);
    r.typed        = typed;
    r.res.status   = st;
    r.res.rkey     = rkey;
    r.res.wake     = wake;
    r.res.woken    = TASK_W'(woken);
    return r;
  endfunction

  // Counts are mostly small so that queues form, with the extremes mixed in.
  function automatic logic signed [COUNT_W-1:0] rand_count();
    case ($urandom_range(0, 9))
      0:       return COUNT_MAX;
      1:       return COUNT_MIN;
      2, 3:    return COUNT_W'($urandom());
      default: return COUNT_W'(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_op();
    int w;
    w = $urandom_range(0, 99);
    if (w < 20) return OP_INIT;
    if (w < 50) return OP_UP;
    if (w < 85) return OP_DOWN;
    return OP_DESTROY;
  endfunction

  // Sends one request transaction and records what it should produce.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic signed [COUNT_W-1:0] cnt,
                              input logic [TASK_W-1:0] tid,
                              input logic typed, input sem_result_t typed_res);
    int          gap;
    sem_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_operation     = op;
    in_sem_key       = key;
    in_initial_count = cnt;
    in_task_id       = tid;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(op, key, cnt, tid);
    pending_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  task automatic send_random(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    send_request(op, key, rand_count(), TASK_W'($urandom()), 1'b0, '0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    sem_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d key 0x%0h",
                 $time, out_status, out_returned_key);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("returned_key", want.rkey, out_returned_key);
        check_field("wake_valid", want.wake, out_wake_valid);
        check_field("woken_task", want.woken, out_woken_task);
      end
    end
  end

  // Result side: each result waits a drawn number of stalled cycles; stalls
  // also fall at random while no result is waiting.
  always @(negedge clk) begin
    if (results_seen != stall_drawn_for) begin
      stall_drawn_for = results_seen;
      stall_hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (out_valid) begin
      out_stall = (stall_hold > 0);
      if (stall_hold > 0) stall_hold--;
    end else begin
      out_stall = !no_idle && ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t        dir_rows[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KEY_W-1:0] k;
    int               kind;
    int               episode;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_INIT;
    in_sem_key       = '0;
    in_initial_count = '0;
    in_task_id       = '0;
    for (int s = 0; s < SEMAPHORES; s++) begin
      tbl_used[s]  = 1'b0;
      ring_head[s] = 0;
      ring_fill[s] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: op, key, count, task, typed, status, key out, wake, woken.
    // Every key is unknown right after reset.
    dir_rows.push_back(stim_row(OP_UP, K_A, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_TOP, -1, 15, 1, ST_NOT_FOUND, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DESTROY, K_ZERO, 32767, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    // Largest count: up saturates; a second init keeps the existing slot.
    dir_rows.push_back(stim_row(OP_INIT, K_ZERO, 32767, 15, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_ZERO, -32768, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_INIT, K_ZERO, -5, 3, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_ZERO, 0, 7, 1, ST_OK, 0, 0, 0));
    // Smallest count: down saturates and still blocks.
    dir_rows.push_back(stim_row(OP_INIT, K_TOP, -32768, 0, 1, ST_OK, 32'h7FFF_FFFF, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_TOP, 0, 15, 1, ST_BLOCKED, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_TOP, 0, 0, 1, ST_BLOCKED, 0, 0, 0));
    // Wake in arrival order, then an up with nobody waiting.
    dir_rows.push_back(stim_row(OP_UP, K_TOP, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_TOP, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_TOP, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_INIT, K_A, 0, 5, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_A, 0, 5, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_A, 0, 10, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_A, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_A, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_A, 0, 0, 0, ST_OK, 0, 0, 0));
    // A destroyed key is unknown again.
    dir_rows.push_back(stim_row(OP_DESTROY, K_TOP, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_TOP, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    // Destroy drops a waiter; the new slot starts with an empty queue.
    dir_rows.push_back(stim_row(OP_DOWN, K_A, 0, 9, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DOWN, K_A, 0, 12, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_DESTROY, K_A, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_INIT, K_A, 2, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_UP, K_A, 0, 0, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(stim_row(OP_INIT, K_B, 21845, 10, 1, ST_OK, {1'b0, K_B}, 0, 0));

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].cnt, dir_rows[i].tid,
                   dir_rows[i].typed, dir_rows[i].res);
    end

    // Random part: a pool larger than the table so that it fills up.
    key_pool[0] = K_ZERO;
    key_pool[1] = K_TOP;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());
    episode = 0;
    while (requests_sent < dir_rows.size() + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind = (episode < 2) ? episode : $urandom_range(0, 5);
      case (kind)
        0: begin
          // Fill one wait queue past its limit, then drain it.
          k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          send_random(OP_DESTROY, k);
          send_request(OP_INIT, k, COUNT_W'(int'($urandom_range(0, 4)) - 2),
                       TASK_W'($urandom()), 1'b0, '0);
          repeat (WAITERS_PER_SEM + 4) send_random(OP_DOWN, k);
          repeat (WAITERS_PER_SEM + 4) send_random(OP_UP, k);
        end
        1: begin
          // Claim every pool key so that the table runs full, then free some.
          for (int i = 0; i < POOL_SIZE; i++) send_random(OP_INIT, key_pool[i]);
          repeat (5) send_random(OP_DESTROY, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
        2, 3, 4: begin
          // Mixed traffic, mostly on known keys.
          repeat (30) begin
            if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom());
            else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_random(rand_op(), k);
          end
        end
        default: begin
          // Noise: every field drawn over its full range.
          repeat (10) begin
            send_request(OP_W'($urandom()), KEY_W'($urandom()), COUNT_W'($urandom()),
                         TASK_W'($urandom()), 1'b0, '0);
          end
        end
      endcase
      episode++;
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
